// ===== hw/rtl/obp_pkg.sv =====
// Shared constants, types and parser phase codes for the object block word parser.
// Used by obp_centroid, obp_parser and object_block_word_parser; depends on nothing.

package obp_pkg;

	localparam int WORD_W = 16;
	localparam int BLOCK_WORDS = 6;
	localparam int IMAGE_WIDTH = 320;

	// Word positions inside an object block.
	localparam int SIG_POS = 1;
	localparam int X_POS = 2;

	localparam int IDX_W = 3;
	localparam int PHASE_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [PHASE_W-1:0] PH_HUNT      = 3'd0;
	localparam logic [PHASE_W-1:0] PH_SECOND    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_COLLECT   = 3'd2;
	localparam logic [PHASE_W-1:0] PH_BLOCK_END = 3'd3;
	localparam logic [PHASE_W-1:0] PH_FRAME_END = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SIG = 2'd1;

	localparam logic [WORD_W-1:0] SYNC_RESET = 16'hAA55;
	localparam logic [WORD_W-1:0] TARGET_RESET = 16'h0001;

	// Centroid scaling: q = floor(a * 2^15 / X_MAX) computed as (a * RECIP) >> RECIP_SH.
	// With a and the reciprocal error both below 2^12, a shift of 24 keeps it exact.
	localparam int X_MAX = IMAGE_WIDTH - 1;
	localparam int XW = (X_MAX > 1) ? $clog2(X_MAX + 1) : 1;
	localparam int RECIP_SH = 24;
	localparam longint unsigned RECIP =
		((64'd1 << (RECIP_SH + 15)) + longint'(X_MAX) - 1) / longint'(X_MAX);
	localparam int RECIP_W = $clog2(RECIP + 1);
	localparam int PROD_W = (XW + 1 + RECIP_W > RECIP_SH + 17) ?
		(XW + 1 + RECIP_W) : (RECIP_SH + 17);

	typedef struct packed {
		logic [WORD_W-1:0] sync_word;
		logic [WORD_W-1:0] target_signature;
	} cfg_t;

	typedef struct packed {
		logic              adv;
		logic [WORD_W-1:0] word;
	} step_t;

endpackage

// ===== hw/rtl/obp_centroid.sv =====
// Combinational horizontal centroid in Q1.15 from a raw x coordinate.
// Depends on obp_pkg for the image width and the reciprocal constant.

module obp_centroid (
	input  logic [obp_pkg::WORD_W-1:0] x_raw,
	output logic signed [15:0]         centroid
);

	logic [obp_pkg::XW-1:0]       x_clamp;
	logic signed [obp_pkg::XW+1:0] diff;
	logic                         neg;
	logic [obp_pkg::XW:0]         mag;
	logic [obp_pkg::PROD_W-1:0]   prod;
	logic [16:0]                  quot;
	logic [16:0]                  quot_neg;

	always_comb begin
		if (x_raw > obp_pkg::WORD_W'(obp_pkg::X_MAX)) begin
			x_clamp = obp_pkg::XW'(obp_pkg::X_MAX);
		end else begin
			x_clamp = x_raw[obp_pkg::XW-1:0];
		end
		diff = $signed({1'b0, x_clamp, 1'b0}) - $signed((obp_pkg::XW+2)'(obp_pkg::X_MAX));
		neg = diff[obp_pkg::XW+1];
		if (neg) begin
			mag = (obp_pkg::XW+1)'(-diff);
		end else begin
			mag = diff[obp_pkg::XW:0];
		end
		// Truncation toward zero: divide the magnitude, then restore the sign.
		prod = obp_pkg::PROD_W'(mag) * obp_pkg::PROD_W'(obp_pkg::RECIP);
		quot = prod[obp_pkg::RECIP_SH +: 17];
		quot_neg = 17'd0 - quot;
		if (neg) begin
			centroid = $signed(quot_neg[15:0]);
		end else if (quot > 17'd32767) begin
			centroid = 16'sh7FFF;
		end else begin
			centroid = $signed(quot[15:0]);
		end
	end

endmodule

// ===== hw/rtl/obp_parser.sv =====
// Sync hunting and block collection state machine with the found/centroid result state.
// Depends on obp_pkg and obp_centroid.

module obp_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  obp_pkg::step_t             step,
	input  obp_pkg::cfg_t              cfg,
	output logic                       found,
	output logic signed [15:0]         centroid
);

	logic [obp_pkg::PHASE_W-1:0] phase_q, phase_d;
	logic [obp_pkg::IDX_W-1:0]   idx_q, idx_d, idx_inc;
	logic                        found_q, found_d;
	logic signed [15:0]          centroid_q, centroid_d;
	logic [obp_pkg::WORD_W-1:0]  sig_q;
	logic signed [15:0]          cand_q;
	logic signed [15:0]          cand_new;
	logic                        is_sync, is_zero;
	logic                        wr_sig, wr_x;

	// Only the signature and x words are ever read back, so x is turned into
	// its centroid as it arrives and the other block words are not kept.
	obp_centroid u_centroid (
		.x_raw    (step.word),
		.centroid (cand_new)
	);

	always_comb begin
		is_sync = (step.word == cfg.sync_word);
		is_zero = (step.word == '0);
		idx_inc = idx_q + obp_pkg::IDX_W'(1);
		phase_d = phase_q;
		idx_d = idx_q;
		found_d = found_q;
		centroid_d = centroid_q;
		wr_sig = 1'b0;
		wr_x = 1'b0;
		unique case (phase_q)
			obp_pkg::PH_HUNT: begin
				if (is_sync) begin
					phase_d = obp_pkg::PH_SECOND;
				end else if (is_zero) begin
					found_d = 1'b0;
					centroid_d = '0;
				end
			end
			obp_pkg::PH_SECOND: begin
				if (is_sync) begin
					idx_d = '0;
					phase_d = obp_pkg::PH_COLLECT;
				end else begin
					if (is_zero) begin
						found_d = 1'b0;
						centroid_d = '0;
					end
					phase_d = obp_pkg::PH_HUNT;
				end
			end
			obp_pkg::PH_COLLECT: begin
				wr_sig = (idx_q == obp_pkg::IDX_W'(obp_pkg::SIG_POS));
				wr_x = (idx_q == obp_pkg::IDX_W'(obp_pkg::X_POS));
				idx_d = idx_inc;
				if (idx_inc == '0 || int'(idx_inc) >= obp_pkg::BLOCK_WORDS) begin
					phase_d = obp_pkg::PH_BLOCK_END;
				end
			end
			obp_pkg::PH_BLOCK_END: begin
				if (is_sync) begin
					idx_d = '0;
					phase_d = obp_pkg::PH_FRAME_END;
					if (sig_q == cfg.target_signature) begin
						found_d = 1'b1;
						centroid_d = cand_q;
					end
				end else begin
					phase_d = obp_pkg::PH_HUNT;
				end
			end
			obp_pkg::PH_FRAME_END: begin
				if (is_sync) begin
					idx_d = '0;
					phase_d = obp_pkg::PH_COLLECT;
				end else if (is_zero) begin
					found_d = 1'b0;
					centroid_d = '0;
					phase_d = obp_pkg::PH_HUNT;
				end else begin
					// This word is the checksum of the next block.
					idx_d = obp_pkg::IDX_W'(1);
					phase_d = obp_pkg::PH_COLLECT;
				end
			end
			default: begin
				phase_d = obp_pkg::PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= obp_pkg::PH_HUNT;
			idx_q <= '0;
			found_q <= 1'b0;
			centroid_q <= '0;
		end else if (step.adv) begin
			phase_q <= phase_d;
			idx_q <= idx_d;
			found_q <= found_d;
			centroid_q <= centroid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step.adv && wr_sig) begin
			sig_q <= step.word;
		end
		if (step.adv && wr_x) begin
			cand_q <= cand_new;
		end
	end

	assign found = found_q;
	assign centroid = centroid_q;

endmodule

// ===== hw/rtl/object_block_word_parser.sv =====
// Top level of the object block word parser: input register, configuration registers,
// output handshake and checks. Depends on obp_pkg and obp_parser.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   input   | in_valid, in_stall, camera_word           | into block
//   output  | out_valid, out_stall, object_found,       | out of block
//           | centroid_q15                              |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// Each accepted word sits in the input register, then moves through the parser into
// the result registers, where its result is presented, once there is room for it
// downstream. One word per cycle is sustained while the output is not stalled.
// Reset returns the parser to hunting for sync and clears the result; the
// configuration registers take 0xAA55 and 1.
// A stalled result holds the input register, which then stalls the input side.

module object_block_word_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [obp_pkg::WORD_W-1:0]      camera_word,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            object_found,
	output logic signed [15:0]              centroid_q15,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [obp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [obp_pkg::WORD_W-1:0]      cfg_data
);

	logic                       valid_s1;
	logic [obp_pkg::WORD_W-1:0] word_s1;
	logic                       out_valid_q;
	logic                       adv;
	logic                       in_take;
	obp_pkg::cfg_t              cfg_q;
	obp_pkg::step_t             step;

	assign adv = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_take = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			word_s1 <= camera_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word <= obp_pkg::SYNC_RESET;
			cfg_q.target_signature <= obp_pkg::TARGET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				obp_pkg::REG_SYNC_WORD: cfg_q.sync_word <= cfg_data;
				obp_pkg::REG_TARGET_SIG: cfg_q.target_signature <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign step.adv = adv;
	assign step.word = word_s1;

	obp_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.cfg      (cfg_q),
		.found    (object_found),
		.centroid (centroid_q15)
	);

	assign out_valid = out_valid_q;

	// A cleared result always carries a zero centroid.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!object_found |-> centroid_q15 == 16'sd0)
		else $error("centroid nonzero while no object is found");

	// The result state moves only when a request passes into the result register.
	a_result_moves_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(adv) |-> ($stable(object_found) && $stable(centroid_q15)))
		else $error("result changed without an advancing request");

	// A request in the input register with room downstream shows up as a result.
	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(out_valid_q && out_stall)) |=> out_valid)
		else $error("advanced request did not produce a result");

endmodule
